@@ design/bsmh_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsmh_pkg: shared types and mix helpers for the byte stream mix hash
// Holds the accumulator triple, the pipeline word format and one mix row.
// ----------------------------------------------------------------------------
package bsmh_pkg;

  localparam int unsigned MixRows    = 9;
  localparam int unsigned BlockBytes = 12;

  // shift amount of each mix row, first row first
  localparam logic [4:0] MIX_SHIFT [MixRows] = '{
    5'd13, 5'd8, 5'd13, 5'd12, 5'd16, 5'd5, 5'd3, 5'd10, 5'd15
  };

  // which accumulator a mix row rewrites
  typedef enum logic [1:0] {
    ROLE_A,
    ROLE_B,
    ROLE_C
  } mix_role_e;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } abc_t;

  // one word traveling through the mix pipeline
  typedef struct packed {
    logic valid;  // slot holds a job
    logic blk;    // a full block was added, block mix runs
    logic fin;    // end of message, closing mix runs and hash leaves
    abc_t acc;    // accumulators under mix
    abc_t tail;   // tail words, length already folded into c
  } job_t;

  // one subtract/subtract/xor-shift row of the mix
  function automatic abc_t mix_row(input mix_role_e role, input logic [4:0] sh,
                                   input abc_t x);
    abc_t y;
    y = x;
    case (role)
      ROLE_A: begin
        y.a = x.a - x.b - x.c;
        y.a = y.a ^ (x.c >> sh);
      end
      ROLE_B: begin
        y.b = x.b - x.c - x.a;
        y.b = y.b ^ (x.a << sh);
      end
      ROLE_C: begin
        y.c = x.c - x.a - x.b;
        y.c = y.c ^ (x.b >> sh);
      end
      default: y = x;
    endcase
    return y;
  endfunction

endpackage
`default_nettype wire

@@ design/byte_stream_mix_hash_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// byte_stream_mix_hash_unit: streaming lookup2-style byte hash
// Hashes each message, one byte per word, and emits the 32-bit c accumulator
// after the closing mix.
// ----------------------------------------------------------------------------
//  channel  dir  tdata                     tuser            tlast
//  s_axis   in   [7:0] data_byte           [0] byte_present last
//  m_axis   out  [31:0] hash_value         -                -
//
// One input word per cycle while s_axis_tready is high. From the launch
// register, a full block goes through a nine-row block mixer, the message end
// through the same nine rows, the junction register, a nine-row closing mixer
// and the output register. The accumulators are read when a block launches
// and written when it leaves the block mixer.
// Reset clears counters, accumulators, pipeline and output valid bits.
// A hash waiting at m_axis sits in the output register; the pipeline holds and
// s_axis_tready is low only while a second hash is ready behind it.
// ----------------------------------------------------------------------------
module byte_stream_mix_hash_unit
  import bsmh_pkg::*;
(
  input  wire  logic        clk_i,
  input  wire  logic        rst_ni,
  input  wire  logic        s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire  logic [0:0]  s_axis_tuser,   // [0] byte_present
  input  wire  logic        s_axis_tlast,
  output logic              m_axis_tvalid,
  input  wire  logic        m_axis_tready,
  output logic [31:0]       m_axis_tdata    // [31:0] hash_value
);

  logic adv;
  logic accept;
  abc_t acc_q, acc_d;
  job_t a_stage [MixRows + 1];
  job_t b_stage [MixRows + 1];
  job_t jct_d;
  job_t jct_q;
  abc_t base;
  logic        out_load;
  logic        out_valid_q;
  logic [31:0] out_hash_q;

  // pipeline moves unless a hash waits at the output and another is behind it
  assign out_load      = !out_valid_q || m_axis_tready;
  assign adv           = !b_stage[MixRows].valid || out_load;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  // byte collection and job launch
  bsmh_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .adv_i          (adv),
    .accept_i       (accept),
    .data_byte_i    (s_axis_tdata),
    .byte_present_i (s_axis_tuser[0]),
    .last_i         (s_axis_tlast),
    .acc_i          (acc_q),
    .job_o          (a_stage[0])
  );

  // block mixer rows
  for (genvar k = 0; k < MixRows; k++) begin : g_block_mix
    bsmh_mix_stage #(
      .Row (k)
    ) u_row (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .job_i  (a_stage[k]),
      .job_o  (a_stage[k + 1])
    );
  end

  // accumulators follow finished blocks and clear at message end
  always_comb begin
    acc_d = acc_q;
    if (adv && a_stage[MixRows].valid) begin
      if (a_stage[MixRows].fin) begin
        acc_d = '0;
      end else if (a_stage[MixRows].blk) begin
        acc_d = a_stage[MixRows].acc;
      end
    end
  end

  // junction: tail and length join the accumulators before the closing mix
  always_comb begin
    base         = a_stage[MixRows].blk ? a_stage[MixRows].acc : acc_q;
    jct_d        = '0;
    jct_d.valid  = a_stage[MixRows].valid && a_stage[MixRows].fin;
    jct_d.fin    = a_stage[MixRows].fin;
    jct_d.acc.a  = base.a + a_stage[MixRows].tail.a;
    jct_d.acc.b  = base.b + a_stage[MixRows].tail.b;
    jct_d.acc.c  = base.c + a_stage[MixRows].tail.c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      jct_q <= '0;
    end else begin
      acc_q <= acc_d;
      if (adv) begin
        jct_q <= jct_d;
      end
    end
  end

  assign b_stage[0] = jct_q;

  // closing mixer rows
  for (genvar k = 0; k < MixRows; k++) begin : g_close_mix
    bsmh_mix_stage #(
      .Row (k)
    ) u_row (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .job_i  (b_stage[k]),
      .job_o  (b_stage[k + 1])
    );
  end

  // output register, a waiting hash stays here while the pipeline runs on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_hash_q  <= 32'd0;
    end else if (out_load) begin
      out_valid_q <= b_stage[MixRows].valid;
      out_hash_q  <= b_stage[MixRows].acc.c;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_hash_q;

  // checks
  logic [MixRows:0] blk_in_flight;
  for (genvar k = 0; k <= MixRows; k++) begin : g_blk_bits
    assign blk_in_flight[k] = a_stage[k].valid && a_stage[k].blk;
  end

  a_one_block_in_mixer : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(blk_in_flight) <= 1)
    else $error("two blocks in the block mixer at once");

  a_acc_clear_after_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && a_stage[MixRows].valid && a_stage[MixRows].fin |=> acc_q == '0)
    else $error("accumulators not cleared after message end");

  a_out_is_message_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_stage[MixRows].valid |-> b_stage[MixRows].fin)
    else $error("output word not from a message end");

  a_out_held_while_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("waiting hash word changed before it was taken");

endmodule
`default_nettype wire

@@ design/bsmh_mix_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsmh_mix_stage: one registered row of the mix
// Applies one subtract/xor/shift row to the accumulators of the word passing
// through; flags and tail words ride along unchanged.
// ----------------------------------------------------------------------------
module bsmh_mix_stage
  import bsmh_pkg::*;
#(
  parameter int unsigned Row = 0
) (
  input  wire  logic clk_i,
  input  wire  logic rst_ni,
  input  wire  logic adv_i,
  input  wire  job_t job_i,
  output job_t       job_o
);

  localparam logic [1:0] RoleCode = 2'(Row % 3);

  job_t job_d;
  job_t job_q;

  // row logic
  always_comb begin
    job_d     = job_i;
    job_d.acc = mix_row(mix_role_e'(RoleCode), MIX_SHIFT[Row], job_i.acc);
  end

  // stage register, held while the pipe stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      job_q <= '0;
    end else if (adv_i) begin
      job_q <= job_d;
    end
  end

  assign job_o = job_q;

endmodule
`default_nettype wire

@@ design/bsmh_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bsmh_front: byte collection and job launch
// Gathers bytes into the 12-byte block, counts the message length and
// launches a job when a block fills or the message ends.
// ----------------------------------------------------------------------------
module bsmh_front
  import bsmh_pkg::*;
(
  input  wire  logic       clk_i,
  input  wire  logic       rst_ni,
  input  wire  logic       adv_i,
  input  wire  logic       accept_i,
  input  wire  logic [7:0] data_byte_i,
  input  wire  logic       byte_present_i,
  input  wire  logic       last_i,
  input  wire  abc_t       acc_i,
  output job_t             job_o
);

  logic [3:0]  pos_q, pos_d;
  logic [31:0] len_q, len_d;
  logic [7:0]  byte_q [BlockBytes];

  logic [7:0]  view      [BlockBytes];
  logic [7:0]  tail_byte [BlockBytes];
  logic [3:0]  cnt;
  logic [3:0]  tail_cnt;
  logic        blk_done;
  logic [31:0] len_inc;
  job_t        job_d;
  job_t        job_q;

  // block view with the incoming byte in place, tail masking
  always_comb begin
    cnt      = pos_q + {3'b000, byte_present_i};
    blk_done = byte_present_i && (pos_q == 4'(BlockBytes - 1));
    tail_cnt = blk_done ? 4'd0 : cnt;
    len_inc  = len_q + {31'd0, byte_present_i};
    for (int i = 0; i < BlockBytes; i++) begin
      view[i]      = (byte_present_i && pos_q == 4'(i)) ? data_byte_i : byte_q[i];
      tail_byte[i] = (4'(i) < tail_cnt) ? view[i] : 8'h00;
    end
  end

  // job word
  always_comb begin
    job_d       = '0;
    job_d.valid = accept_i && (blk_done || last_i);
    job_d.blk   = blk_done;
    job_d.fin   = last_i;
    job_d.acc.a = acc_i.a + {view[3], view[2], view[1], view[0]};
    job_d.acc.b = acc_i.b + {view[7], view[6], view[5], view[4]};
    job_d.acc.c = acc_i.c + {view[11], view[10], view[9], view[8]};
    job_d.tail.a = {tail_byte[3], tail_byte[2], tail_byte[1], tail_byte[0]};
    job_d.tail.b = {tail_byte[7], tail_byte[6], tail_byte[5], tail_byte[4]};
    job_d.tail.c = len_inc + {tail_byte[10], tail_byte[9], tail_byte[8], 8'h00};
  end

  // position and length for the next word
  always_comb begin
    pos_d = pos_q;
    len_d = len_q;
    if (accept_i) begin
      if (last_i) begin
        pos_d = 4'd0;
        len_d = 32'd0;
      end else begin
        pos_d = blk_done ? 4'd0 : cnt;
        len_d = len_inc;
      end
    end
  end

  // counters and launch register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 4'd0;
      len_q <= 32'd0;
      job_q <= '0;
    end else begin
      pos_q <= pos_d;
      len_q <= len_d;
      if (adv_i) begin
        job_q <= job_d;
      end
    end
  end

  // block byte store
  always_ff @(posedge clk_i) begin
    if (accept_i && byte_present_i) begin
      byte_q[pos_q] <= data_byte_i;
    end
  end

  assign job_o = job_q;

endmodule
`default_nettype wire
